@@ rtl/gas_pkg.sv @@
// Shared types and constants of the grid A* path search block.
// Holds the configuration and result structs, cell codes and item modes.
// No dependencies.
package gas_pkg;

  localparam int GRID_DIM = 32;  // side of the square cell store
  localparam int CW      = 5;   // row or column field width
  localparam int DIM_W   = 6;   // grid_rows / grid_cols width
  localparam int CODE_W  = 2;
  localparam int COST_W  = 11;
  localparam int H_W     = 6;   // heuristic width, up to 62
  localparam int F_W     = 12;
  localparam int EXPL_W  = 16;

  localparam logic [1:0] MODE_WRITE  = 2'd0;
  localparam logic [1:0] MODE_SEARCH = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;

  localparam logic [CODE_W-1:0] CODE_FREE    = 2'd0;
  localparam logic [CODE_W-1:0] CODE_BLOCKED = 2'd1;
  localparam logic [CODE_W-1:0] CODE_GOAL    = 2'd2;
  localparam logic [CODE_W-1:0] CODE_PATH    = 2'd3;

  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  typedef struct packed {
    logic [DIM_W-1:0] grid_rows;
    logic [DIM_W-1:0] grid_cols;
    logic [CW-1:0]    start_row;
    logic [CW-1:0]    start_col;
    logic [CW-1:0]    goal_row;
    logic [CW-1:0]    goal_col;
    logic             heuristic_kind;
  } cfg_t;

  typedef struct packed {
    logic [CODE_W-1:0] cell_code_out;
    logic              path_found;
    logic [EXPL_W-1:0] nodes_explored;
    logic              open_overflow;
  } res_t;

  typedef struct packed {
    logic [COST_W-1:0] cost;
    logic              visited;
    logic [CW-1:0]     prow;
    logic [CW-1:0]     pcol;
  } node_t;

  typedef struct packed {
    logic [F_W-1:0] f;
    logic [CW-1:0]  row;
    logic [CW-1:0]  col;
  } open_t;

  // zero acts as one, anything beyond the store acts as the store size
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int lim);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (int'(v) > lim) r = DIM_W'(lim);
    return r;
  endfunction

endpackage

@@ rtl/gas_heur.sv @@
// Heuristic unit: Manhattan distance, ready in the cycle after start, or floored
// Euclidean distance through a bit-serial square root. Depends on gas_pkg.
module gas_heur (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic                    kind,
  input  logic [gas_pkg::CW-1:0]  row,
  input  logic [gas_pkg::CW-1:0]  col,
  input  logic [gas_pkg::CW-1:0]  goal_row,
  input  logic [gas_pkg::CW-1:0]  goal_col,
  output logic                    done,
  output logic [gas_pkg::H_W-1:0] h
);

  localparam int SQ_W = 2 * gas_pkg::CW + 1;
  localparam int K_W  = $clog2(gas_pkg::H_W);

  logic              busy;
  logic [SQ_W-1:0]   sq;
  logic [K_W-1:0]    k;
  logic [gas_pkg::CW-1:0]  dr, dc;
  logic [gas_pkg::H_W-1:0] trial;
  logic [2*gas_pkg::H_W-1:0] trial_sq;

  assign dr = (row > goal_row) ? row - goal_row : goal_row - row;
  assign dc = (col > goal_col) ? col - goal_col : goal_col - col;
  assign trial    = h | (gas_pkg::H_W'(1) << k);
  assign trial_sq = trial * trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (!busy) begin
        if (start) begin
          if (kind) begin
            h    <= gas_pkg::H_W'(dr) + gas_pkg::H_W'(dc);
            done <= 1'b1;
          end else begin
            sq   <= SQ_W'(dr) * SQ_W'(dr) + SQ_W'(dc) * SQ_W'(dc);
            h    <= '0;
            k    <= K_W'(gas_pkg::H_W - 1);
            busy <= 1'b1;
          end
        end
      end else begin
        // one root bit per cycle, most significant first
        if ((2*gas_pkg::H_W)'(sq) >= trial_sq) h <= trial;
        if (k == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          k <= k - 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/gas_search.sv @@
// Search engine: grid, node and open-list memories and the sequencer that
// serves cell writes, cell reads and A* runs. Depends on gas_pkg, gas_heur.
module gas_search #(
  parameter int OPEN_DEPTH = 2048
) (
  input  logic                       clk,
  input  logic                       rst,
  input  gas_pkg::cfg_t              cfg,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 mode,
  input  logic [gas_pkg::CW-1:0]     cell_row,
  input  logic [gas_pkg::CW-1:0]     cell_col,
  input  logic [gas_pkg::CODE_W-1:0] cell_code_in,
  input  logic                       res_free,
  output logic                       res_load,
  output gas_pkg::res_t              res
);

  localparam int CELLS = gas_pkg::GRID_DIM * gas_pkg::GRID_DIM;
  localparam int IDX_W = $clog2(CELLS);
  localparam int CNT_W = $clog2(CELLS + 1);
  localparam int OA_W  = $clog2(OPEN_DEPTH);
  localparam int OC_W  = $clog2(OPEN_DEPTH + 1);

  localparam logic [3:0] S_IDLE = 4'd0,  S_RD   = 4'd1,  S_DONE = 4'd2,  S_CLR  = 4'd3;
  localparam logic [3:0] S_INIT = 4'd4,  S_IHW  = 4'd5,  S_POP  = 4'd6,  S_SCAN = 4'd7;
  localparam logic [3:0] S_LAST = 4'd8,  S_VIS  = 4'd9,  S_NB   = 4'd10, S_NBC  = 4'd11;
  localparam logic [3:0] S_NBH  = 4'd12, S_BT   = 4'd13, S_BT2  = 4'd14;

  function automatic logic [IDX_W-1:0] cell_idx(input logic [gas_pkg::CW-1:0] r,
                                                input logic [gas_pkg::CW-1:0] c);
    return IDX_W'(IDX_W'(r) * IDX_W'(gas_pkg::GRID_DIM)) + IDX_W'(c);
  endfunction

  // memories
  logic [gas_pkg::CODE_W-1:0] grid_mem [CELLS];
  gas_pkg::node_t             node_mem [CELLS];
  gas_pkg::open_t             open_mem [OPEN_DEPTH];

  logic                       g_we, n_we, o_we;
  logic [IDX_W-1:0]           g_wa, g_ra, n_wa, n_ra;
  logic [OA_W-1:0]            o_wa, o_ra;
  logic [gas_pkg::CODE_W-1:0] g_wd, g_rd;
  gas_pkg::node_t             n_wd, n_rd;
  gas_pkg::open_t             o_wd, o_rd;

  always_ff @(posedge clk) begin
    if (g_we) grid_mem[g_wa] <= g_wd;
    g_rd <= grid_mem[g_ra];
  end
  always_ff @(posedge clk) begin
    if (n_we) node_mem[n_wa] <= n_wd;
    n_rd <= node_mem[n_ra];
  end
  always_ff @(posedge clk) begin
    if (o_we) open_mem[o_wa] <= o_wd;
    o_rd <= open_mem[o_ra];
  end

  // sequencer state
  logic [3:0]                  state;
  logic [CNT_W-1:0]            sweep;
  logic [OC_W-1:0]             count, p;
  logic                        v;
  logic [OA_W-1:0]             q, best_idx;
  logic [gas_pkg::F_W-1:0]     best_f;
  logic [gas_pkg::CW-1:0]      best_r, best_c, cur_r, cur_c, nb_r, nb_c, walk_r, walk_c;
  logic [gas_pkg::COST_W-1:0]  cur_cost;
  logic [1:0]                  dir;
  logic                        rd_inside;

  logic [gas_pkg::DIM_W-1:0]   rows_eff, cols_eff;
  logic                        accept, in_grid, run_ok;
  logic                        cand_ok;
  logic [gas_pkg::CW-1:0]      cand_r, cand_c;
  logic [gas_pkg::COST_W-1:0]  ng;
  logic                        h_start, h_done;
  logic [gas_pkg::CW-1:0]      h_row, h_col;
  logic [gas_pkg::H_W-1:0]     h;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign rows_eff = gas_pkg::clamp_dim(cfg.grid_rows, gas_pkg::GRID_DIM);
  assign cols_eff = gas_pkg::clamp_dim(cfg.grid_cols, gas_pkg::GRID_DIM);
  assign in_grid  = (int'(cell_row) < gas_pkg::GRID_DIM) &&
                    (int'(cell_col) < gas_pkg::GRID_DIM);
  assign run_ok   = ({1'b0, cfg.start_row} < rows_eff) && ({1'b0, cfg.start_col} < cols_eff) &&
                    ({1'b0, cfg.goal_row} < rows_eff) && ({1'b0, cfg.goal_col} < cols_eff);
  assign ng       = cur_cost + 1'b1;
  assign res_load = (state == S_DONE) && res_free;

  always_comb begin
    cand_ok = 1'b0;
    cand_r  = cur_r;
    cand_c  = cur_c;
    unique case (dir)
      gas_pkg::DIR_UP: begin
        cand_ok = cur_r != '0;
        cand_r  = cur_r - 1'b1;
      end
      gas_pkg::DIR_DOWN: begin
        cand_ok = ({1'b0, cur_r} + 1'b1) < rows_eff;
        cand_r  = cur_r + 1'b1;
      end
      gas_pkg::DIR_LEFT: begin
        cand_ok = cur_c != '0;
        cand_c  = cur_c - 1'b1;
      end
      default: begin
        cand_ok = ({1'b0, cur_c} + 1'b1) < cols_eff;
        cand_c  = cur_c + 1'b1;
      end
    endcase
  end

  assign h_start = (state == S_INIT) ||
                   ((state == S_NBC) && (g_rd != gas_pkg::CODE_BLOCKED) &&
                    !n_rd.visited && (ng < n_rd.cost));
  assign h_row   = (state == S_INIT) ? cfg.start_row : nb_r;
  assign h_col   = (state == S_INIT) ? cfg.start_col : nb_c;

  gas_heur u_heur (
    .clk      (clk),
    .rst      (rst),
    .start    (h_start),
    .kind     (cfg.heuristic_kind),
    .row      (h_row),
    .col      (h_col),
    .goal_row (cfg.goal_row),
    .goal_col (cfg.goal_col),
    .done     (h_done),
    .h        (h)
  );

  // memory port control
  always_comb begin
    g_we = 1'b0; g_wa = '0; g_wd = '0; g_ra = '0;
    n_we = 1'b0; n_wa = '0; n_wd = '0; n_ra = '0;
    o_we = 1'b0; o_wa = '0; o_wd = '0; o_ra = '0;
    unique case (state)
      S_IDLE: begin
        g_ra = cell_idx(cell_row, cell_col);
        g_wa = cell_idx(cell_row, cell_col);
        g_wd = cell_code_in;
        g_we = accept && (mode == gas_pkg::MODE_WRITE) && in_grid;
      end
      S_CLR: begin
        n_we = 1'b1;
        n_wa = sweep[IDX_W-1:0];
        n_wd = '{cost: '1, visited: 1'b0, prow: '0, pcol: '0};
      end
      S_INIT: begin
        n_we = 1'b1;
        n_wa = cell_idx(cfg.start_row, cfg.start_col);
        n_wd = '0;
      end
      S_IHW: begin
        o_we = h_done;
        o_wa = '0;
        o_wd = '{f: gas_pkg::F_W'(h), row: cfg.start_row, col: cfg.start_col};
      end
      S_SCAN: begin
        o_ra = (p < count) ? p[OA_W-1:0] : OA_W'(count - 1'b1);
      end
      S_LAST: begin
        o_we = 1'b1;
        o_wa = best_idx;
        o_wd = o_rd;
        n_ra = cell_idx(best_r, best_c);
      end
      S_VIS: begin
        n_we = !n_rd.visited;
        n_wa = cell_idx(cur_r, cur_c);
        n_wd = n_rd;
        n_wd.visited = 1'b1;
      end
      S_NB: begin
        g_ra = cell_idx(cand_r, cand_c);
        n_ra = cell_idx(cand_r, cand_c);
      end
      S_NBC: begin
        n_we = h_start;
        n_wa = cell_idx(nb_r, nb_c);
        n_wd = '{cost: ng, visited: 1'b0, prow: cur_r, pcol: cur_c};
      end
      S_NBH: begin
        o_we = h_done && (int'(count) < OPEN_DEPTH);
        o_wa = count[OA_W-1:0];
        o_wd = '{f: gas_pkg::F_W'(ng) + gas_pkg::F_W'(h), row: nb_r, col: nb_c};
      end
      S_BT: begin
        g_ra = cell_idx(walk_r, walk_c);
        n_ra = cell_idx(walk_r, walk_c);
      end
      S_BT2: begin
        g_we = g_rd != gas_pkg::CODE_GOAL;
        g_wa = cell_idx(walk_r, walk_c);
        g_wd = gas_pkg::CODE_PATH;
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            rd_inside <= in_grid;
            unique case (mode)
              gas_pkg::MODE_WRITE: begin
                res   <= '{cell_code_out: cell_code_in, path_found: 1'b0,
                           nodes_explored: '0, open_overflow: 1'b0};
                state <= S_DONE;
              end
              gas_pkg::MODE_READ: begin
                res   <= '0;
                state <= S_RD;
              end
              gas_pkg::MODE_SEARCH: begin
                res   <= '0;
                count <= '0;
                sweep <= '0;
                state <= run_ok ? S_CLR : S_DONE;
              end
              default: begin
                res   <= '0;
                state <= S_DONE;
              end
            endcase
          end
        end
        S_RD: begin
          res.cell_code_out <= rd_inside ? g_rd : gas_pkg::CODE_FREE;
          state <= S_DONE;
        end
        S_CLR: begin
          sweep <= sweep + 1'b1;
          if (sweep == CNT_W'(CELLS - 1)) state <= S_INIT;
        end
        S_INIT: state <= S_IHW;
        S_IHW: begin
          if (h_done) begin
            count <= OC_W'(1);
            state <= S_POP;
          end
        end
        S_POP: begin
          p      <= '0;
          v      <= 1'b0;
          best_f <= '1;
          state  <= (count == '0) ? S_DONE : S_SCAN;
        end
        S_SCAN: begin
          // stream the list through the read port; keep the first minimum
          if (p < count) p <= p + 1'b1;
          v <= p < count;
          q <= p[OA_W-1:0];
          if (v) begin
            if (o_rd.f < best_f) begin
              best_f   <= o_rd.f;
              best_idx <= q;
              best_r   <= o_rd.row;
              best_c   <= o_rd.col;
            end
            if (OC_W'(q) == count - 1'b1) state <= S_LAST;
          end
        end
        S_LAST: begin
          count <= count - 1'b1;
          cur_r <= best_r;
          cur_c <= best_c;
          if (res.nodes_explored != '1) res.nodes_explored <= res.nodes_explored + 1'b1;
          state <= S_VIS;
        end
        S_VIS: begin
          cur_cost <= n_rd.cost;
          dir      <= gas_pkg::DIR_UP;
          if (n_rd.visited) begin
            state <= S_POP;
          end else if (cur_r == cfg.goal_row && cur_c == cfg.goal_col) begin
            walk_r <= cfg.goal_row;
            walk_c <= cfg.goal_col;
            state  <= S_BT;
          end else begin
            state <= S_NB;
          end
        end
        S_NB: begin
          nb_r <= cand_r;
          nb_c <= cand_c;
          if (cand_ok) state <= S_NBC;
          else if (dir == gas_pkg::DIR_RIGHT) state <= S_POP;
          else dir <= dir + 1'b1;
        end
        S_NBC: begin
          if (h_start) state <= S_NBH;
          else if (dir == gas_pkg::DIR_RIGHT) state <= S_POP;
          else begin
            dir   <= dir + 1'b1;
            state <= S_NB;
          end
        end
        S_NBH: begin
          if (h_done) begin
            if (int'(count) < OPEN_DEPTH) count <= count + 1'b1;
            else res.open_overflow <= 1'b1;
            if (dir == gas_pkg::DIR_RIGHT) state <= S_POP;
            else begin
              dir   <= dir + 1'b1;
              state <= S_NB;
            end
          end
        end
        S_BT: begin
          if (walk_r == cfg.start_row && walk_c == cfg.start_col) begin
            res.path_found <= 1'b1;
            state <= S_DONE;
          end else begin
            state <= S_BT2;
          end
        end
        S_BT2: begin
          walk_r <= n_rd.prow;
          walk_c <= n_rd.pcol;
          state  <= S_BT;
        end
        S_DONE: begin
          if (res_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/grid_astar_path_search.sv @@
// Top level of the grid A* path search block: APB register file, stream
// ports and result register around the search engine.
// Depends on gas_pkg and gas_search.
//
//   channel   | direction | handshake               | payload
//   ----------+-----------+-------------------------+--------------------------------
//   s_axis    | in        | s_axis_tvalid/tready    | mode, cell_row, cell_col, code
//   m_axis    | out       | m_axis_tvalid/tready    | code, found, explored, overflow
//   apb       | in        | psel/penable/pready     | seven configuration registers
//
// A cell write passes through S_DONE, a cell read through S_RD and S_DONE. A
// search first sweeps the node memory, all GRID_DIM*GRID_DIM entries, then for
// each pop runs the first-minimum scan through the open-list read port and
// checks the neighbours (a queued neighbour waits longer on the Euclidean root).
// Reset is synchronous and clears control state only; grid contents survive.
// A finished result waits in the output register while the next item is
// taken; the engine stalls only when it has a result and that register is full.
module grid_astar_path_search #(
  parameter int OPEN_DEPTH = 2048
) (
  input  logic        clk,
  input  logic        rst,
  // stream in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [1:0] mode, [6:2] cell_row, [11:7] cell_col,
                                     // [13:12] cell_code_in, [15:14] zero
  // stream out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // [1:0] cell_code_out, [2] path_found,
                                     // [18:3] nodes_explored, [19] open_overflow, [23:20] zero
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [2:0] REG_ROWS  = 3'd0;
  localparam logic [2:0] REG_COLS  = 3'd1;
  localparam logic [2:0] REG_SROW  = 3'd2;
  localparam logic [2:0] REG_SCOL  = 3'd3;
  localparam logic [2:0] REG_GROW  = 3'd4;
  localparam logic [2:0] REG_GCOL  = 3'd5;
  localparam logic [2:0] REG_HKIND = 3'd6;

  gas_pkg::cfg_t cfg;
  gas_pkg::res_t res, out_res;
  logic          res_load, res_free, wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  // register file; the work proper only reads it
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.grid_rows      <= gas_pkg::DIM_W'(32);
      cfg.grid_cols      <= gas_pkg::DIM_W'(32);
      cfg.start_row      <= '0;
      cfg.start_col      <= '0;
      cfg.goal_row       <= '0;
      cfg.goal_col       <= '0;
      cfg.heuristic_kind <= 1'b1;
    end else if (wr) begin
      unique case (paddr[4:2])
        REG_ROWS:  cfg.grid_rows      <= pwdata[gas_pkg::DIM_W-1:0];
        REG_COLS:  cfg.grid_cols      <= pwdata[gas_pkg::DIM_W-1:0];
        REG_SROW:  cfg.start_row      <= pwdata[gas_pkg::CW-1:0];
        REG_SCOL:  cfg.start_col      <= pwdata[gas_pkg::CW-1:0];
        REG_GROW:  cfg.goal_row       <= pwdata[gas_pkg::CW-1:0];
        REG_GCOL:  cfg.goal_col       <= pwdata[gas_pkg::CW-1:0];
        REG_HKIND: cfg.heuristic_kind <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[4:2])
      REG_ROWS:  prdata = 32'(cfg.grid_rows);
      REG_COLS:  prdata = 32'(cfg.grid_cols);
      REG_SROW:  prdata = 32'(cfg.start_row);
      REG_SCOL:  prdata = 32'(cfg.start_col);
      REG_GROW:  prdata = 32'(cfg.goal_row);
      REG_GCOL:  prdata = 32'(cfg.goal_col);
      REG_HKIND: prdata = 32'(cfg.heuristic_kind);
      default:   prdata = '0;
    endcase
  end

  gas_search #(
    .OPEN_DEPTH (OPEN_DEPTH)
  ) u_search (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .mode         (s_axis_tdata[1:0]),
    .cell_row     (s_axis_tdata[6:2]),
    .cell_col     (s_axis_tdata[11:7]),
    .cell_code_in (s_axis_tdata[13:12]),
    .res_free     (res_free),
    .res_load     (res_load),
    .res          (res)
  );

  // output register: free when empty or being taken this cycle
  assign res_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_free) begin
      m_axis_tvalid <= res_load;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) out_res <= res;
  end

  assign m_axis_tdata = {4'b0, out_res.open_overflow, out_res.nodes_explored,
                         out_res.path_found, out_res.cell_code_out};

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for grid_astar_path_search: drives cell writes, reads
// and searches over the stream port and configures through APB.
// Depends on gas_pkg and the grid_astar_path_search RTL.
module testbench;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int DIM        = 32;
  localparam int FILL       = 16;
  localparam int CELLS      = DIM * DIM;
  localparam int OPEN_MAX   = 2048;
  localparam int IDLE_LIMIT = 20000000;
  localparam int REG_ROWS = 0, REG_COLS = 1, REG_SROW = 2, REG_SCOL = 3;
  localparam int REG_GROW = 4, REG_GCOL = 5, REG_HEUR = 6;

  logic        clk, rst;
  logic        in_valid, in_ready;
  logic [15:0] in_data;
  logic        out_valid, out_ready;
  logic [23:0] out_data;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;

  grid_astar_path_search u_top (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(in_valid), .s_axis_tready(in_ready), .s_axis_tdata(in_data),
    .m_axis_tvalid(out_valid), .m_axis_tready(out_ready), .m_axis_tdata(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Predictor state: configuration, grid and search scratch
  logic [5:0]  cfg_rows = 6'd32, cfg_cols = 6'd32;
  logic [4:0]  cfg_srow = '0, cfg_scol = '0, cfg_grow = '0, cfg_gcol = '0;
  logic        cfg_heur = 1'b1;
  logic [1:0]  grid_cells [CELLS];
  int unsigned cost_to [CELLS];
  bit          closed [CELLS];
  int unsigned came_from [CELLS];
  int unsigned open_cell [OPEN_MAX];
  int unsigned open_f [OPEN_MAX];
  int unsigned open_n;

  logic [15:0]   pending_items [$];
  gas_pkg::res_t expected_results [$];
  int            errors = 0;
  int            idle_pct = 0, stall_pct = 0;
  bit            sent;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned root_floor(int unsigned v);
    int unsigned r;
    r = 0;
    while ((r + 1) * (r + 1) <= v) r++;
    return r;
  endfunction

  function automatic int unsigned dist_to_goal(int unsigned r, int unsigned c);
    int unsigned dr, dc;
    dr = (r > cfg_grow) ? r - cfg_grow : cfg_grow - r;
    dc = (c > cfg_gcol) ? c - cfg_gcol : cfg_gcol - c;
    if (cfg_heur) return dr + dc;
    return root_floor(dr * dr + dc * dc);
  endfunction

  function automatic int unsigned used_dim(logic [5:0] v);
    if (v == 0) return 1;
    return (v > DIM) ? DIM : v;
  endfunction

  // A* over the model grid; marks the path into grid_cells on success
  function automatic gas_pkg::res_t run_astar();
    gas_pkg::res_t res;
    int unsigned rows, cols, start, goal, cur, cr, cc, best, walk, steps, nb, ng;
    int nr, nc;
    rows = used_dim(cfg_rows);
    cols = used_dim(cfg_cols);
    res = '0;
    open_n = 0;
    if (!(cfg_srow < rows && cfg_scol < cols && cfg_grow < rows && cfg_gcol < cols))
      return res;
    for (int i = 0; i < CELLS; i++) begin
      cost_to[i] = 32'hFFFF_FFFF;
      closed[i] = 0;
    end
    start = cfg_srow * DIM + cfg_scol;
    goal  = cfg_grow * DIM + cfg_gcol;
    cost_to[start] = 0;
    open_cell[0] = start;
    open_f[0] = dist_to_goal(cfg_srow, cfg_scol);
    open_n = 1;
    while (open_n > 0) begin
      // first minimum f, then fill the hole with the last entry
      best = 0;
      for (int unsigned i = 1; i < open_n; i++)
        if (open_f[i] < open_f[best]) best = i;
      cur = open_cell[best];
      open_n--;
      open_cell[best] = open_cell[open_n];
      open_f[best] = open_f[open_n];
      cr = cur / DIM;
      cc = cur % DIM;
      if (res.nodes_explored != 16'hFFFF) res.nodes_explored++;
      if (closed[cur]) continue;
      closed[cur] = 1;
      if (cur == goal) begin
        walk = goal;
        steps = 0;
        while (walk != start && steps < CELLS) begin
          if (grid_cells[walk] != gas_pkg::CODE_GOAL) grid_cells[walk] = gas_pkg::CODE_PATH;
          walk = came_from[walk];
          steps++;
        end
        res.path_found = 1'b1;
        break;
      end
      for (int d = 0; d < 4; d++) begin
        nr = int'(cr) + ((d == 0) ? -1 : (d == 1) ? 1 : 0);
        nc = int'(cc) + ((d == 2) ? -1 : (d == 3) ? 1 : 0);
        if (nr < 0 || nc < 0 || nr >= int'(rows) || nc >= int'(cols)) continue;
        nb = nr * DIM + nc;
        if (grid_cells[nb] == gas_pkg::CODE_BLOCKED || closed[nb]) continue;
        ng = cost_to[cur] + 1;
        if (ng < cost_to[nb]) begin
          cost_to[nb] = ng;
          if (open_n < OPEN_MAX) begin
            open_cell[open_n] = nb;
            open_f[open_n] = ng + dist_to_goal(nr, nc);
            open_n++;
          end else begin
            res.open_overflow = 1'b1;
          end
          came_from[nb] = cur;
        end
      end
    end
    return res;
  endfunction

  function automatic gas_pkg::res_t predict_transfer(logic [15:0] item);
    gas_pkg::res_t res;
    logic [1:0] mode, code;
    logic [4:0] r, c;
    mode = item[1:0];
    r = item[6:2];
    c = item[11:7];
    code = item[13:12];
    res = '0;
    case (mode)
      gas_pkg::MODE_WRITE: begin
        grid_cells[r * DIM + c] = code;
        res.cell_code_out = code;
      end
      gas_pkg::MODE_SEARCH: res = run_astar();
      gas_pkg::MODE_READ:   res.cell_code_out = grid_cells[r * DIM + c];
      default:              res = '0;
    endcase
    return res;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d, want %0d", what, got, want);
    errors++;
  endtask

  // Driver: change inputs on the falling edge only
  always @(negedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      in_data   <= '0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || sent) begin
        if (pending_items.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
          in_data  <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Monitor: sample on the rising edge, predict on input transfer, check outputs
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    gas_pkg::res_t want;
    sent <= !rst && in_valid && in_ready;
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_results.push_back(predict_transfer(in_data));
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report("unexpected result", out_data[19:0], 0);
        end else begin
          want = expected_results.pop_front();
          if (out_data[1:0] !== want.cell_code_out)
            report("cell_code_out", out_data[1:0], want.cell_code_out);
          if (out_data[2] !== want.path_found)
            report("path_found", out_data[2], want.path_found);
          if (out_data[18:3] !== want.nodes_explored)
            report("nodes_explored", out_data[18:3], want.nodes_explored);
          if (out_data[19] !== want.open_overflow)
            report("open_overflow", out_data[19], want.open_overflow);
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT) begin
          $display("FAIL grid_astar_path_search");
          $finish;
        end
      end
    end
  end

  function automatic logic [15:0] pack_item(logic [1:0] mode, logic [4:0] r,
                                            logic [4:0] c, logic [1:0] code);
    return {2'b00, code, c, r, mode};
  endfunction

  function automatic logic [1:0] random_code();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 65) return gas_pkg::CODE_FREE;
    if (p < 88) return gas_pkg::CODE_BLOCKED;
    if (p < 94) return gas_pkg::CODE_GOAL;
    return gas_pkg::CODE_PATH;
  endfunction

  // APB write with a setup and an access phase; the model register follows at the access edge
  task automatic reg_write(int idx, int unsigned value);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 5'(idx * 4); pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      REG_ROWS: cfg_rows = value[5:0];
      REG_COLS: cfg_cols = value[5:0];
      REG_SROW: cfg_srow = value[4:0];
      REG_SCOL: cfg_scol = value[4:0];
      REG_GROW: cfg_grow = value[4:0];
      REG_GCOL: cfg_gcol = value[4:0];
      default:  cfg_heur = value[0];
    endcase
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Hold until every queued item has been transferred and answered
  task automatic drain();
    wait (pending_items.size() == 0 && !in_valid && expected_results.size() == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(int rows, int cols, int sr, int sc, int gr, int gc, int h);
    drain();
    reg_write(REG_ROWS, rows);
    reg_write(REG_COLS, cols);
    reg_write(REG_SROW, sr);
    reg_write(REG_SCOL, sc);
    reg_write(REG_GROW, gr);
    reg_write(REG_GCOL, gc);
    reg_write(REG_HEUR, h);
  endtask

  initial begin
    int rows, cols, p, n;
    logic [4:0] r, c;
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Fill the top-left block so that no read or search sees an unwritten cell
    for (int i = 0; i < FILL * FILL; i++)
      pending_items.push_back(pack_item(gas_pkg::MODE_WRITE, 5'(i / FILL), 5'(i % FILL),
                                        ($urandom_range(0, 99) < 12) ? gas_pkg::CODE_BLOCKED
                                                                      : gas_pkg::CODE_FREE));
    // blocked row and column just outside the block keep big searches inside it
    for (int i = 0; i <= FILL; i++) begin
      pending_items.push_back(pack_item(gas_pkg::MODE_WRITE, 5'(FILL), 5'(i),
                                        gas_pkg::CODE_BLOCKED));
      if (i < FILL)
        pending_items.push_back(pack_item(gas_pkg::MODE_WRITE, 5'(i), 5'(FILL),
                                          gas_pkg::CODE_BLOCKED));
    end
    // start equals goal at reset settings: one pop, nothing marked
    pending_items.push_back(pack_item(gas_pkg::MODE_SEARCH, 5'd0, 5'd0, gas_pkg::CODE_FREE));

    configure(4, 4, 0, 0, 3, 3, 1);
    for (int i = 0; i < 16; i++)
      pending_items.push_back(pack_item(gas_pkg::MODE_WRITE, 5'(i / 4), 5'(i % 4),
                                        gas_pkg::CODE_FREE));
    pending_items.push_back(pack_item(gas_pkg::MODE_WRITE, 5'd3, 5'd3, gas_pkg::CODE_GOAL));
    pending_items.push_back(pack_item(gas_pkg::MODE_WRITE, 5'd0, 5'd0, gas_pkg::CODE_BLOCKED));
    pending_items.push_back(pack_item(gas_pkg::MODE_SEARCH, 5'd31, 5'd31, gas_pkg::CODE_PATH));
    pending_items.push_back(pack_item(gas_pkg::MODE_READ, 5'd1, 5'd0, gas_pkg::CODE_FREE));
    pending_items.push_back(pack_item(gas_pkg::MODE_WRITE, 5'd31, 5'd31, gas_pkg::CODE_PATH));
    pending_items.push_back(pack_item(gas_pkg::MODE_READ, 5'd31, 5'd31, gas_pkg::CODE_GOAL));
    pending_items.push_back(pack_item(MODE_UNUSED, 5'd31, 5'd31, gas_pkg::CODE_PATH));
    pending_items.push_back(pack_item(gas_pkg::MODE_READ, 5'd3, 5'd3, gas_pkg::CODE_FREE));

    // start outside the used area: empty search
    configure(4, 4, 5, 0, 3, 3, 0);
    pending_items.push_back(pack_item(gas_pkg::MODE_SEARCH, 5'd0, 5'd0, gas_pkg::CODE_FREE));
    // zero size acts as one cell
    configure(0, 0, 0, 0, 0, 0, 0);
    pending_items.push_back(pack_item(gas_pkg::MODE_SEARCH, 5'd0, 5'd0, gas_pkg::CODE_FREE));
    // oversize acts as the full store, Euclidean, across the walled block
    configure(63, 63, 0, 0, FILL - 1, FILL - 1, 0);
    pending_items.push_back(pack_item(gas_pkg::MODE_WRITE, 5'd0, 5'd0, gas_pkg::CODE_FREE));
    pending_items.push_back(pack_item(gas_pkg::MODE_SEARCH, 5'd0, 5'd0, gas_pkg::CODE_FREE));

    // Random phases: small grids, random mixes of writes, searches, reads and unused modes
    for (int ph = 0; ph < 20; ph++) begin
      p = $urandom_range(0, 19);
      rows = (p == 1) ? 0 : $urandom_range(1, 10);
      cols = (p == 2) ? 0 : $urandom_range(1, 10);
      n = used_dim(rows);
      r = ($urandom_range(0, 7) == 0) ? 5'($urandom) : 5'($urandom_range(0, n - 1));
      c = 5'($urandom_range(0, n - 1));
      n = used_dim(cols);
      configure(rows, cols, r, $urandom_range(0, n - 1), $urandom_range(0, used_dim(rows) - 1),
                ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(0, n - 1),
                $urandom_range(0, 1));
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 72; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 72; end
        default: begin idle_pct = 14; stall_pct = 14; end
      endcase
      for (int k = 0; k < 20; k++) begin
        p = $urandom_range(0, 99);
        r = 5'($urandom_range(0, used_dim(rows) - 1));
        c = 5'($urandom_range(0, used_dim(cols) - 1));
        if (p < 45)
          pending_items.push_back(pack_item(gas_pkg::MODE_WRITE, r, c, random_code()));
        else if (p < 68)
          pending_items.push_back(pack_item(gas_pkg::MODE_SEARCH, 5'($urandom), 5'($urandom),
                                            2'($urandom)));
        else if (p < 88)
          pending_items.push_back(pack_item(gas_pkg::MODE_READ, r, c, 2'($urandom)));
        else if (p < 94)
          pending_items.push_back(pack_item(MODE_UNUSED, 5'($urandom), 5'($urandom),
                                            2'($urandom)));
        else
          pending_items.push_back(pack_item(gas_pkg::MODE_WRITE, 5'($urandom), 5'($urandom),
                                            random_code()));
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("PASS grid_astar_path_search");
    end else begin
      $display("FAIL grid_astar_path_search");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/gas_pkg.sv
rtl/gas_heur.sv
rtl/gas_search.sv
rtl/grid_astar_path_search.sv
sim/testbench.sv
